// File: hdl/bts_pkg.sv
package bts_pkg;

    // Default width of the string length counter.
    localparam int LENGTH_BITS_DEFAULT = 24;

    // Bencode structure characters.
    localparam logic [7:0] CHAR_I     = 8'h69;  // 'i'
    localparam logic [7:0] CHAR_L     = 8'h6c;  // 'l'
    localparam logic [7:0] CHAR_D     = 8'h64;  // 'd'
    localparam logic [7:0] CHAR_E     = 8'h65;  // 'e'
    localparam logic [7:0] CHAR_COLON = 8'h3a;  // ':'
    localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CHAR_NINE  = 8'h39;  // '9'

    // Token kinds.
    localparam logic KIND_STRING  = 1'b0;
    localparam logic KIND_INTEGER = 1'b1;

    // One result word.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       token_kind;
        logic       token_end;
        logic       error_flag;
    } result_t;

endpackage

// File: hdl/bts_scan_core.sv
module bts_scan_core #(
    parameter int LENGTH_BITS = bts_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic [7:0]       in_byte,
    output logic             has_result,
    output bts_pkg::result_t result
);
    import bts_pkg::*;

    localparam logic [2:0] MODE_READY  = 3'd0;
    localparam logic [2:0] MODE_INT    = 3'd1;
    localparam logic [2:0] MODE_LIST   = 3'd2;
    localparam logic [2:0] MODE_DICT   = 3'd3;
    localparam logic [2:0] MODE_LENGTH = 3'd4;
    localparam logic [2:0] MODE_STRING = 3'd5;
    localparam logic [2:0] MODE_HALTED = 3'd6;

    localparam int WIDE_BITS = LENGTH_BITS + 4;

    logic [2:0]             mode_reg, mode_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic [LENGTH_BITS-1:0] taken_reg, taken_next;

    logic                   is_digit;
    logic [7:0]             digit_byte;
    logic [3:0]             digit_val;
    logic [WIDE_BITS-1:0]   len_times_ten;
    logic [WIDE_BITS-1:0]   len_sum;
    logic                   len_overflow;
    logic [LENGTH_BITS-1:0] taken_inc;
    logic                   last_byte;

    assign is_digit      = in_byte inside {[CHAR_ZERO:CHAR_NINE]};
    assign digit_byte    = in_byte - CHAR_ZERO;
    assign digit_val     = digit_byte[3:0];
    // Times ten as a pair of shifted adds.
    assign len_times_ten = {1'b0, len_reg, 3'b000} + {3'b000, len_reg, 1'b0};
    assign len_sum       = len_times_ten + {{(WIDE_BITS-4){1'b0}}, digit_val};
    assign len_overflow  = |len_sum[WIDE_BITS-1:LENGTH_BITS];
    assign taken_inc     = taken_reg + {{(LENGTH_BITS-1){1'b0}}, 1'b1};
    assign last_byte     = taken_inc >= len_reg;

    always_comb begin
        mode_next  = mode_reg;
        len_next   = len_reg;
        taken_next = taken_reg;
        has_result = 1'b0;
        result     = '0;
        case (mode_reg)
            MODE_READY, MODE_LIST, MODE_DICT: begin
                if (in_byte == CHAR_I) begin
                    mode_next = MODE_INT;
                end else if (is_digit) begin
                    len_next   = {{(LENGTH_BITS-4){1'b0}}, digit_val};
                    taken_next = '0;
                    mode_next  = MODE_LENGTH;
                end else if (mode_reg == MODE_READY) begin
                    if (in_byte == CHAR_L) begin
                        mode_next = MODE_LIST;
                    end else if (in_byte == CHAR_D) begin
                        mode_next = MODE_DICT;
                    end
                end else if (in_byte == CHAR_E) begin
                    mode_next = MODE_READY;
                end
            end
            MODE_INT: begin
                has_result        = 1'b1;
                result.token_kind = KIND_INTEGER;
                if (in_byte == CHAR_E) begin
                    result.token_end = 1'b1;
                    mode_next        = MODE_READY;
                end else if (is_digit) begin
                    result.out_byte   = in_byte;
                    result.byte_valid = 1'b1;
                end else begin
                    result.error_flag = 1'b1;
                    mode_next         = MODE_HALTED;
                end
            end
            MODE_LENGTH: begin
                if (is_digit) begin
                    if (len_overflow) begin
                        has_result        = 1'b1;
                        result.error_flag = 1'b1;
                        mode_next         = MODE_HALTED;
                    end else begin
                        len_next = len_sum[LENGTH_BITS-1:0];
                    end
                end else if (in_byte == CHAR_COLON) begin
                    taken_next = '0;
                    if (len_reg == '0) begin
                        // An empty string ends right at the colon.
                        has_result       = 1'b1;
                        result.token_end = 1'b1;
                        mode_next        = MODE_READY;
                    end else begin
                        mode_next = MODE_STRING;
                    end
                end else begin
                    mode_next = MODE_READY;
                end
            end
            MODE_STRING: begin
                has_result        = 1'b1;
                result.out_byte   = in_byte;
                result.byte_valid = 1'b1;
                taken_next        = taken_inc;
                if (last_byte) begin
                    result.token_end = 1'b1;
                    mode_next        = MODE_READY;
                end
            end
            default: begin
                mode_next = MODE_HALTED;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_READY;
            len_reg   <= '0;
            taken_reg <= '0;
        end else if (step) begin
            mode_reg  <= mode_next;
            len_reg   <= len_next;
            taken_reg <= taken_next;
        end
    end

endmodule

// File: hdl/bts_out_reg.sv
module bts_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  bts_pkg::result_t load_data,
    output logic             can_load,
    output logic             m_valid,
    input  logic             m_ready,
    output bts_pkg::result_t m_data
);
    import bts_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    // The register can be refilled in the same cycle its word is taken.
    assign can_load = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_data   = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

endmodule

// File: hdl/bencode_token_scanner.sv
// Bencode token scanner.
//
// The s_ channel takes one raw stream byte per word on s_in_byte. The m_
// channel gives one word per token byte or marker: m_out_byte with
// m_byte_valid, m_token_kind (0 string, 1 integer), m_token_end and
// m_error_flag. Structure bytes and string length digits give no word.
//
// A byte taken sits in the input register, and its word is loaded into
// the result register when that register is free. Throughput is one byte
// per cycle while the result register can take each word; the only loop
// is the scan state update with its length multiply-by-ten and compare.
//
// When the receiver stalls, the result register holds its word and the
// input register keeps the next byte, so s_ready drops only once both are
// full. Bytes that give no word pass through without needing the result
// register. Reset clears the scan state to ready and empties both
// registers. After an error word the scanner halts and drops every byte
// until reset.
module bencode_token_scanner #(
    parameter int LENGTH_BITS = bts_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_byte_valid,
    output logic       m_token_kind,
    output logic       m_token_end,
    output logic       m_error_flag
);
    import bts_pkg::*;

    // Input register: holds one stream byte until the scanner takes it.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    logic       advance;
    logic       can_load;
    logic       has_result;
    result_t    core_result;
    result_t    out_data;

    // A byte is scanned only when the result register can take whatever
    // word it produces; the state then moves in the same edge. A byte that
    // produces no word is scanned even while the result register is full.
    assign advance = in_valid_reg && (can_load || !has_result);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
        end
    end

    bts_scan_core #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_scan_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .in_byte   (in_byte_reg),
        .has_result(has_result),
        .result    (core_result)
    );

    bts_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && has_result),
        .load_data(core_result),
        .can_load (can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (out_data)
    );

    assign m_out_byte   = out_data.out_byte;
    assign m_byte_valid = out_data.byte_valid;
    assign m_token_kind = out_data.token_kind;
    assign m_token_end  = out_data.token_end;
    assign m_error_flag = out_data.error_flag;

endmodule

// File: hdl/bts_checker.sv
module bts_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [7:0] s_in_byte,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic       m_byte_valid,
    input logic       m_token_kind,
    input logic       m_token_end,
    input logic       m_error_flag
);

    // A waiting stream word holds still until it is taken.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_in_byte))
        else $error("stream word changed while waiting");

    // A stalled result word holds still.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) &&
        $stable(m_byte_valid) && $stable(m_token_kind) &&
        $stable(m_token_end) && $stable(m_error_flag))
        else $error("result word changed while stalled");

    // Once the error word is taken, the scanner is halted and stays silent.
    a_halt_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_error_flag |=> !m_valid)
        else $error("word produced after error");

    // The error word carries no byte and ends no token.
    a_error_bare: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error_flag |-> !m_byte_valid && !m_token_end &&
        m_out_byte == 8'h00)
        else $error("error word carries content");

    // An integer token ends on a byte-less marker.
    a_int_end_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_token_kind && m_token_end |-> !m_byte_valid &&
        m_out_byte == 8'h00)
        else $error("integer end marker carries a byte");

endmodule

bind bencode_token_scanner bts_checker u_bts_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_in_byte   (s_in_byte),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_out_byte  (m_out_byte),
    .m_byte_valid(m_byte_valid),
    .m_token_kind(m_token_kind),
    .m_token_end (m_token_end),
    .m_error_flag(m_error_flag)
);

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import bts_pkg::*;

    // The scanner is built with its default length counter width, and the
    // predictor below works at that same width.
    localparam int LEN_BITS = LENGTH_BITS_DEFAULT;
    localparam longint unsigned LEN_MAX = (64'd1 << LEN_BITS) - 64'd1;

    // The run ends with a failure if it is still going after this many cycles.
    // A correct run needs only a small fraction of it.
    localparam int CYCLE_LIMIT = 200000;

    // After the last expected word has arrived, this many more cycles are
    // allowed for a stray word to show up.
    localparam int DRAIN_CYCLES = 16;

    // Scan state of the predictor. The encoding follows the block's own.
    typedef enum logic [2:0] {
        SCAN_READY,
        SCAN_INT,
        SCAN_LIST,
        SCAN_DICT,
        SCAN_LENGTH,
        SCAN_STRING,
        SCAN_HALTED
    } scan_mode_t;

    // Each phase of the run has its own pattern of idle and stall cycles.
    typedef enum int {
        PH_STEADY,
        PH_SENDER_IDLE,
        PH_RECEIVER_STALL,
        PH_BOTH_IDLE
    } phase_t;

    // One stream byte waiting to be sent, tagged with the phase it belongs to.
    typedef struct {
        logic [7:0] data;
        phase_t     phase;
    } stream_item_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_byte_valid;
    logic       m_token_kind;
    logic       m_token_end;
    logic       m_error_flag;

    stream_item_t stream_bytes[$];
    result_t      due_words[$];
    phase_t       cur_phase = PH_STEADY;
    int           mismatch_count = 0;
    int           words_seen = 0;
    int           cycle_count = 0;

    // Copy of the scan state that the predictor keeps.
    scan_mode_t      mode_now = SCAN_READY;
    longint unsigned len_field = 0;
    longint unsigned payload_seen = 0;

    bencode_token_scanner #(
        .LENGTH_BITS(LEN_BITS)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_byte_valid(m_byte_valid),
        .m_token_kind(m_token_kind),
        .m_token_end (m_token_end),
        .m_error_flag(m_error_flag)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic bit is_digit(input logic [7:0] b);
        return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    endfunction

    // Predicts the scanner's response to one accepted stream byte. It
    // returns 1 and fills the word when the byte produces a result.
    function automatic bit scan_byte(input logic [7:0] b, output result_t word);
        longint unsigned grown;
        bit              has_word;
        word = '0;
        has_word = 1'b0;
        case (mode_now)
            SCAN_READY, SCAN_LIST, SCAN_DICT: begin
                // Between tokens, only 'i' and a length digit open a token.
                // 'l' and 'd' open a container only from ready, because
                // nesting is not tracked. 'e' closes a container. Every other
                // byte is dropped.
                if (b == CHAR_I) begin
                    mode_now = SCAN_INT;
                end else if (is_digit(b)) begin
                    len_field = 64'(b - CHAR_ZERO);
                    payload_seen = 0;
                    mode_now = SCAN_LENGTH;
                end else if (mode_now == SCAN_READY) begin
                    if (b == CHAR_L) begin
                        mode_now = SCAN_LIST;
                    end else if (b == CHAR_D) begin
                        mode_now = SCAN_DICT;
                    end
                end else if (b == CHAR_E) begin
                    mode_now = SCAN_READY;
                end
            end
            SCAN_INT: begin
                has_word = 1'b1;
                word.token_kind = KIND_INTEGER;
                if (b == CHAR_E) begin
                    word.token_end = 1'b1;
                    mode_now = SCAN_READY;
                end else if (is_digit(b)) begin
                    word.out_byte = b;
                    word.byte_valid = 1'b1;
                end else begin
                    // Any non-digit other than 'e' inside an integer, a minus sign
                    // included, is an error and halts the scanner.
                    word.error_flag = 1'b1;
                    mode_now = SCAN_HALTED;
                end
            end
            SCAN_LENGTH: begin
                if (is_digit(b)) begin
                    grown = len_field * 10 + 64'(b - CHAR_ZERO);
                    if (grown > LEN_MAX) begin
                        has_word = 1'b1;
                        word.token_kind = KIND_STRING;
                        word.error_flag = 1'b1;
                        mode_now = SCAN_HALTED;
                    end else begin
                        len_field = grown;
                    end
                end else if (b == CHAR_COLON) begin
                    payload_seen = 0;
                    if (len_field == 0) begin
                        // An empty string is complete at its colon.
                        has_word = 1'b1;
                        word.token_kind = KIND_STRING;
                        word.token_end = 1'b1;
                        mode_now = SCAN_READY;
                    end else begin
                        mode_now = SCAN_STRING;
                    end
                end else begin
                    // A length cut short by any other byte drops the token.
                    mode_now = SCAN_READY;
                end
            end
            SCAN_STRING: begin
                payload_seen = (payload_seen + 1) & LEN_MAX;
                has_word = 1'b1;
                word.out_byte = b;
                word.byte_valid = 1'b1;
                word.token_kind = KIND_STRING;
                if (payload_seen >= len_field) begin
                    word.token_end = 1'b1;
                    mode_now = SCAN_READY;
                end
            end
            default: begin
                mode_now = SCAN_HALTED;
            end
        endcase
        return has_word;
    endfunction

    function automatic int sender_idle_pct(input phase_t ph);
        return (ph == PH_SENDER_IDLE) ? 55 : (ph == PH_BOTH_IDLE) ? 23 : 0;
    endfunction

    function automatic int receiver_stall_pct(input phase_t ph);
        return (ph == PH_RECEIVER_STALL) ? 55 : (ph == PH_BOTH_IDLE) ? 23 : 0;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        $display("ERROR at %0t ns: %s", $time, what);
    endtask

    task automatic push_byte(input logic [7:0] b, input phase_t ph);
        stream_item_t item;
        item.data = b;
        item.phase = ph;
        stream_bytes.insert(stream_bytes.size(), item);
    endtask

    task automatic push_text(input string s, input phase_t ph);
        for (int k = 0; k < s.len(); k++) begin
            push_byte(s[k], ph);
        end
    endtask

    // Appends one random token or piece of filler. Filler bytes never open
    // an integer or a length, so no error can happen before the tail.
    // That keeps the scanner out of its halted state for the whole random part.
    task automatic add_random_token(input phase_t ph);
        int         pick;
        int         count;
        string      digits;
        logic [7:0] b;
        pick = $urandom_range(99);
        if (pick < 30) begin
            // An integer with zero to five digits.
            push_byte(CHAR_I, ph);
            count = $urandom_range(5);
            repeat (count) push_byte(8'(CHAR_ZERO + $urandom_range(9)), ph);
            push_byte(CHAR_E, ph);
        end else if (pick < 65) begin
            // A string. Most are short, and some lengths carry leading zeros.
            count = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8);
            digits = $sformatf("%0d", count);
            if ($urandom_range(4) == 0) begin
                digits = {"00", digits};
            end
            push_text({digits, ":"}, ph);
            repeat (count) push_byte(8'($urandom_range(255)), ph);
        end else if (pick < 73) begin
            push_byte(CHAR_L, ph);
        end else if (pick < 81) begin
            push_byte(CHAR_D, ph);
        end else if (pick < 89) begin
            push_byte(CHAR_E, ph);
        end else if (pick < 95) begin
            do begin
                b = 8'($urandom_range(255));
            end while (b == CHAR_I || is_digit(b));
            push_byte(b, ph);
        end else begin
            // A length that ends with some byte other than a colon.
            count = $urandom_range(3, 1);
            repeat (count) push_byte(8'(CHAR_ZERO + $urandom_range(9)), ph);
            do begin
                b = 8'($urandom_range(255));
            end while (b == CHAR_COLON || is_digit(b));
            push_byte(b, ph);
        end
    endtask

    // The driver sends one stream word at a time from the pending queue. It
    // feeds the predictor at the edge where each word is accepted. A new
    // word, or an idle cycle, is set up only once the current word has gone.
    // So valid never drops while a word is waiting.
    always @(posedge aclk) begin
        result_t predicted;
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_in_byte <= 8'h00;
        end else begin
            if (s_valid && s_ready) begin
                if (scan_byte(s_in_byte, predicted)) begin
                    due_words.insert(due_words.size(), predicted);
                end
            end
            if (!s_valid || s_ready) begin
                if (stream_bytes.size() != 0 &&
                    $urandom_range(99) >= sender_idle_pct(stream_bytes[0].phase)) begin
                    s_valid <= 1'b1;
                    s_in_byte <= stream_bytes[0].data;
                    cur_phase <= stream_bytes[0].phase;
                    void'(stream_bytes.pop_front());
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // The monitor checks every accepted result word against the oldest
    // prediction. It stalls the result channel at random, following the
    // phase of the word most recently sent.
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_out_byte, m_byte_valid, m_token_kind, m_token_end, m_error_flag};
                if (due_words.size() == 0) begin
                    flag_mismatch($sformatf("word %0d arrived with none expected: %p",
                                            words_seen, got));
                end else begin
                    want = due_words.pop_front();
                    if (got !== want) begin
                        flag_mismatch($sformatf(
                            "word %0d: byte %h valid %b kind %b end %b err %b, expected %s",
                            words_seen, got.out_byte, got.byte_valid, got.token_kind,
                            got.token_end, got.error_flag,
                            $sformatf("byte %h valid %b kind %b end %b err %b",
                                      want.out_byte, want.byte_valid, want.token_kind,
                                      want.token_end, want.error_flag)));
                    end
                end
                words_seen++;
            end
            m_ready <= ($urandom_range(99) >= receiver_stall_pct(cur_phase));
        end
    end

    // The watchdog stops a run that hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin
        string      digits;
        logic [7:0] b;

        // Directed opening: integers with the extreme digits and an empty
        // integer; an empty string; a string carrying the extreme byte values;
        // nested containers; a dict with a dropped byte inside; a length cut
        // short; and control characters between tokens.
        push_text("i09e", PH_STEADY);
        push_text("ie", PH_STEADY);
        push_text("0:", PH_STEADY);
        push_text("3:", PH_STEADY);
        push_byte(8'h00, PH_STEADY);
        push_byte(8'hff, PH_STEADY);
        push_byte(8'h80, PH_STEADY);
        push_text("ldli5e", PH_STEADY);
        push_text("le", PH_STEADY);
        push_text("dxe", PH_STEADY);
        push_text("5x", PH_STEADY);
        push_byte(8'h00, PH_STEADY);
        push_byte(8'h1f, PH_STEADY);

        // Random part: about a hundred words in each of the four phases.
        for (int p = 0; p < 4; p++) begin
            int first;
            first = stream_bytes.size();
            while (stream_bytes.size() - first < 100) begin
                add_random_token(phase_t'(p));
            end
        end

        // The tail first sends a length at the counter's maximum, which must
        // not overflow. It then ends in one of three errors, chosen at
        // random, because the scanner halts for good after an error. A few
        // bytes after the error must produce nothing.
        push_text({$sformatf("%0d", LEN_MAX), ";"}, PH_STEADY);
        case ($urandom_range(2))
            0: push_text("i12-", PH_STEADY);
            1: begin
                push_text("i7", PH_STEADY);
                do begin
                    b = 8'($urandom_range(255));
                end while (b == CHAR_E || is_digit(b));
                push_byte(b, PH_STEADY);
            end
            default: begin
                digits = $sformatf("%0d", LEN_MAX + 1);
                push_text(digits, PH_STEADY);
            end
        endcase
        push_text("i5e3:abc0:", PH_STEADY);

        // Reset is held low at the start, and the block sees it synchronously.
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait until every stream word has been accepted, then until every
        // predicted word has arrived. Then allow a stray one time to show up.
        while (stream_bytes.size() != 0 || s_valid) @(posedge aclk);
        while (due_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (due_words.size() != 0) begin
            flag_mismatch($sformatf("%0d expected words never arrived", due_words.size()));
        end
        if (mismatch_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/bts_pkg.sv
hdl/bts_scan_core.sv
hdl/bts_out_reg.sv
hdl/bencode_token_scanner.sv
hdl/bts_checker.sv
tb/sv/testbench.sv
